@@ rtl/core/twn_pkg.sv @@
package twn_pkg;

  localparam logic [7:0] MARK0 = 8'hE2;
  localparam logic [7:0] MARK1 = 8'h96;
  localparam logic [7:0] MARK2 = 8'h81;
  localparam logic [7:0] SPACE = 8'h20;

  // One input byte can cause at most four pieces and six output bytes.
  localparam int MAX_PIECES = 4;
  localparam int MAX_BYTES  = 6;

  localparam logic [1:0] SP_NONE = 2'd0;
  localparam logic [1:0] SP_ONE  = 2'd1;
  localparam logic [1:0] SP_RUN  = 2'd2;

  localparam logic [1:0] REG_COLLAPSE = 2'd0;
  localparam logic [1:0] REG_PREFIX   = 2'd1;
  localparam logic [1:0] REG_LIMIT    = 2'd2;

  // A piece is either the three-byte marker or one plain byte.
  typedef struct packed {
    logic       mark;
    logic [7:0] value;
  } twn_piece_t;

  // All results caused by one input byte, handed from front to back.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] data;
    logic [2:0]                count;
    logic                      bare;
    logic                      last;
    logic                      ovf;
  } twn_entry_t;

endpackage

@@ rtl/core/token_whitespace_normalizer.sv @@
// Whitespace normalizer for a tokenizer front end. Text bytes go in one per
// transfer, the last byte of each text flagged by last_in, and the normalized
// bytes come out one per transfer, with run_last on the final result of each
// input byte and text_end on the final result of the text. The front stage
// takes one byte per cycle and turns it into all of its results at once;
// a small queue of QUEUE_DEPTH entries holds those groups, and the output
// side hands out one byte per cycle while pop is held and the queue is not
// empty. A byte with several results (up to six, for a marker, held bytes
// and the byte itself) holds the output until all are taken; the input
// stalls only when the queue is full. Configuration writes take effect at
// once and belong where no transfer is in flight; a change in the middle of
// a text applies from the next byte on.
module token_whitespace_normalizer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        last_in,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        run_last,
  output logic        text_end,
  output logic        overflow
);
  import twn_pkg::*;

  logic       accept;
  logic       entry_push;
  twn_entry_t entry;
  twn_entry_t head;
  logic       head_pop;

  assign accept = push && !full;

  twn_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .in_byte    (in_byte),
    .last_in    (last_in),
    .entry_push (entry_push),
    .entry      (entry)
  );

  twn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (entry_push),
    .wr_data (entry),
    .full    (full),
    .rd_en   (head_pop),
    .rd_data (head),
    .empty   (empty)
  );

  twn_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_empty (empty),
    .head_pop   (head_pop),
    .pop        (pop),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .run_last   (run_last),
    .text_end   (text_end),
    .overflow   (overflow)
  );

endmodule

@@ rtl/core/twn_front.sv @@
module twn_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  logic                last_in,
  output logic                entry_push,
  output twn_pkg::twn_entry_t entry
);
  import twn_pkg::*;

  logic        collapse_mode;
  logic        add_prefix;
  logic [15:0] out_limit;

  logic [1:0]  space_pending, space_pending_next;
  logic        seen_content, seen_content_next;
  logic [1:0]  held_count, held_count_next;
  logic [15:0] held_bytes, held_bytes_next;
  logic [1:0]  byte_position;
  logic [15:0] out_count, out_count_next;
  logic        overflowed, overflowed_next;

  twn_piece_t [MAX_PIECES-1:0] pc;
  logic [2:0]                  npc;
  logic                        do_release;
  logic                        do_content;
  logic [7:0]                  expect_byte;

  logic [3:0]  cum;
  logic [2:0]  fit_n;
  logic [2:0]  used;
  logic [2:0]  pos;
  logic [MAX_BYTES-1:0][7:0] bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      collapse_mode <= 1'b1;
      add_prefix    <= 1'b1;
      out_limit     <= 16'd8191;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COLLAPSE: collapse_mode <= cfg_data[0];
        REG_PREFIX:   add_prefix    <= cfg_data[0];
        REG_LIMIT:    out_limit     <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Build the list of pieces this byte causes, before the length check.
  always_comb begin : build
    space_pending_next = space_pending;
    seen_content_next  = seen_content;
    held_count_next    = held_count;
    held_bytes_next    = held_bytes;
    npc                = 3'd0;
    pc                 = '0;
    do_release         = 1'b0;
    do_content         = 1'b0;
    expect_byte        = (held_count == 2'd1) ? MARK1 : MARK2;

    if (collapse_mode || held_count != 2'd0) begin
      if (held_count != 2'd0) begin
        if (in_byte == expect_byte) begin
          if (held_count == 2'd2) begin
            pc[npc[1:0]] = '{mark: 1'b0, value: MARK0};
            npc = npc + 3'd1;
            pc[npc[1:0]] = '{mark: 1'b0, value: MARK1};
            npc = npc + 3'd1;
            pc[npc[1:0]] = '{mark: 1'b0, value: MARK2};
            npc = npc + 3'd1;
            held_count_next    = 2'd0;
            held_bytes_next    = '0;
            seen_content_next  = 1'b1;
            space_pending_next = SP_NONE;
          end else begin
            held_bytes_next[15:8] = in_byte;
            held_count_next       = 2'd2;
            do_release            = last_in;
          end
        end else begin
          do_release = 1'b1;
          do_content = 1'b1;
        end
      end else if (byte_position == 2'd0 && in_byte == MARK0) begin
        held_count_next = 2'd1;
        held_bytes_next = {8'h00, MARK0};
        do_release      = last_in;
      end else begin
        do_content = 1'b1;
      end

      if (do_release) begin
        if (add_prefix) begin
          pc[npc[1:0]] = '{mark: 1'b1, value: 8'h00};
          npc = npc + 3'd1;
        end
        if (held_count_next != 2'd0) begin
          pc[npc[1:0]] = '{mark: 1'b0, value: held_bytes_next[7:0]};
          npc = npc + 3'd1;
        end
        if (held_count_next == 2'd2) begin
          pc[npc[1:0]] = '{mark: 1'b0, value: held_bytes_next[15:8]};
          npc = npc + 3'd1;
        end
        held_count_next    = 2'd0;
        held_bytes_next    = '0;
        seen_content_next  = 1'b1;
        space_pending_next = SP_NONE;
      end

      if (do_content) begin
        if (in_byte == SPACE) begin
          if (seen_content_next) begin
            space_pending_next = SP_ONE;
          end
        end else begin
          if (!seen_content_next) begin
            if (add_prefix) begin
              pc[npc[1:0]] = '{mark: 1'b1, value: 8'h00};
              npc = npc + 3'd1;
            end
            seen_content_next = 1'b1;
          end else if (space_pending_next != SP_NONE) begin
            pc[npc[1:0]] = '{mark: 1'b1, value: 8'h00};
            npc = npc + 3'd1;
          end
          space_pending_next = SP_NONE;
          pc[npc[1:0]] = '{mark: 1'b0, value: in_byte};
          npc = npc + 3'd1;
        end
      end
    end else begin
      if (byte_position == 2'd0 && add_prefix) begin
        pc[npc[1:0]] = '{mark: 1'b1, value: 8'h00};
        npc = npc + 3'd1;
      end
      if (in_byte == SPACE) begin
        if (space_pending == SP_NONE) begin
          space_pending_next = SP_ONE;
        end else if (space_pending == SP_ONE) begin
          pc[npc[1:0]] = '{mark: 1'b0, value: SPACE};
          npc = npc + 3'd1;
          pc[npc[1:0]] = '{mark: 1'b0, value: SPACE};
          npc = npc + 3'd1;
          space_pending_next = SP_RUN;
        end else begin
          pc[npc[1:0]] = '{mark: 1'b0, value: SPACE};
          npc = npc + 3'd1;
        end
      end else begin
        if (space_pending == SP_ONE) begin
          pc[npc[1:0]] = '{mark: 1'b1, value: 8'h00};
          npc = npc + 3'd1;
        end
        space_pending_next = SP_NONE;
        pc[npc[1:0]] = '{mark: 1'b0, value: in_byte};
        npc = npc + 3'd1;
      end
      // A single space left open at the end of the text becomes a marker.
      if (last_in && space_pending_next == SP_ONE) begin
        pc[npc[1:0]] = '{mark: 1'b1, value: 8'h00};
        npc = npc + 3'd1;
      end
    end
  end

  // Pieces only grow the running length, so the ones that fit form a
  // prefix of the list and each can be checked on its own.
  always_comb begin : fit
    cum   = 4'd0;
    fit_n = 3'd0;
    used  = 3'd0;
    for (int k = 0; k < MAX_PIECES; k++) begin
      cum = cum + (pc[k].mark ? 4'd3 : 4'd1);
      if (3'(k) < npc && !overflowed &&
          ({1'b0, out_count} + 17'(cum)) <= {1'b0, out_limit}) begin
        fit_n = 3'(k + 1);
        used  = cum[2:0];
      end
    end
    overflowed_next = overflowed | (fit_n != npc);
    out_count_next  = out_count + 16'(used);
  end

  always_comb begin : expand
    pos   = 3'd0;
    bytes = '0;
    for (int k = 0; k < MAX_PIECES; k++) begin
      if (3'(k) < fit_n) begin
        if (pc[k].mark) begin
          bytes[pos]              = MARK0;
          bytes[3'(pos + 3'd1)]   = MARK1;
          bytes[3'(pos + 3'd2)]   = MARK2;
          pos = pos + 3'd3;
        end else begin
          bytes[pos] = pc[k].value;
          pos = pos + 3'd1;
        end
      end
    end
  end

  always_comb begin
    entry.data  = bytes;
    entry.bare  = (used == 3'd0);
    entry.count = (used == 3'd0) ? 3'd1 : used;
    entry.last  = last_in;
    entry.ovf   = overflowed_next;
    entry_push  = accept && (used != 3'd0 || last_in);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      space_pending <= SP_NONE;
      seen_content  <= 1'b0;
      held_count    <= 2'd0;
      held_bytes    <= '0;
      byte_position <= 2'd0;
      out_count     <= '0;
      overflowed    <= 1'b0;
    end else if (accept) begin
      if (last_in) begin
        space_pending <= SP_NONE;
        seen_content  <= 1'b0;
        held_count    <= 2'd0;
        held_bytes    <= '0;
        byte_position <= 2'd0;
        out_count     <= '0;
        overflowed    <= 1'b0;
      end else begin
        space_pending <= space_pending_next;
        seen_content  <= seen_content_next;
        held_count    <= held_count_next;
        held_bytes    <= held_bytes_next;
        byte_position <= (byte_position == 2'd3) ? 2'd3 : byte_position + 2'd1;
        out_count     <= out_count_next;
        overflowed    <= overflowed_next;
      end
    end
  end

endmodule

@@ rtl/core/twn_queue.sv @@
module twn_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  twn_pkg::twn_entry_t wr_data,
  output logic                full,
  input  logic                rd_en,
  output twn_pkg::twn_entry_t rd_data,
  output logic                empty
);
  import twn_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  twn_entry_t      slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_wr;
  logic            do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/twn_back.sv @@
module twn_back (
  input  logic                clk,
  input  logic                rst,
  input  twn_pkg::twn_entry_t head,
  input  logic                head_empty,
  output logic                head_pop,
  input  logic                pop,
  output logic [7:0]          out_byte,
  output logic                byte_valid,
  output logic                run_last,
  output logic                text_end,
  output logic                overflow
);
  import twn_pkg::*;

  logic [2:0] idx;
  logic       transfer;

  assign transfer   = pop && !head_empty;
  assign run_last   = (idx == head.count - 3'd1);
  assign out_byte   = head.bare ? 8'h00 : head.data[idx];
  assign byte_valid = !head.bare;
  assign text_end   = head.last && run_last;
  assign overflow   = head.ovf;
  assign head_pop   = transfer && run_last;

  // Steps through the bytes of the head entry, one per transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 3'd0;
    end else if (transfer) begin
      idx <= run_last ? 3'd0 : idx + 3'd1;
    end
  end

endmodule

@@ tb/sv/twn_checker.sv @@
module twn_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  in_byte,
  input  logic        last_in,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  out_byte,
  input  logic        byte_valid,
  input  logic        run_last,
  input  logic        text_end,
  input  logic        overflow,
  output int          fails,
  output int          backlog
);
  timeunit 1ns;
  timeprecision 1ps;
  import twn_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       valid;
    logic       run_end;
    logic       txt_end;
    logic       ovf;
  } norm_res_t;

  norm_res_t   norm_out_q[$];

  // Register copies.
  logic        mode_collapse;
  logic        prefix_on;
  logic [15:0] limit;

  // Per-text state.
  logic [1:0]  sp_state;
  logic        content_seen;
  logic [1:0]  hold_n;
  logic [15:0] hold_data;
  logic [1:0]  pos;
  logic [15:0] emitted;
  logic        ovf_flag;

  logic [7:0]  step_bytes[MAX_BYTES];
  int          step_n;

  // A piece either fits whole within the limit or sets the overflow flag,
  // after which nothing more of the text is produced.
  function automatic void emit_piece(int len, logic [23:0] seq);
    int i;
    if (ovf_flag) return;
    if (32'(emitted) + len > 32'(limit)) begin
      ovf_flag = 1'b1;
      return;
    end
    for (i = 0; i < len; i++) begin
      if (step_n < MAX_BYTES) begin
        step_bytes[step_n] = seq[8*(len-1-i) +: 8];
        step_n++;
      end
    end
    emitted = emitted + 16'(len);
  endfunction

  function automatic void emit_mark();
    emit_piece(3, {MARK0, MARK1, MARK2});
  endfunction

  function automatic void emit_byte(logic [7:0] b);
    emit_piece(1, {16'h0000, b});
  endfunction

  function automatic void release_hold();
    if (prefix_on) emit_mark();
    if (hold_n >= 2'd1) emit_byte(hold_data[7:0]);
    if (hold_n >= 2'd2) emit_byte(hold_data[15:8]);
    hold_n = 2'd0;
    hold_data = 16'h0000;
    content_seen = 1'b1;
    sp_state = SP_NONE;
  endfunction

  function automatic void collapse_content(logic [7:0] b);
    if (b == SPACE) begin
      if (content_seen) sp_state = SP_ONE;
      return;
    end
    if (!content_seen) begin
      if (prefix_on) emit_mark();
      content_seen = 1'b1;
    end else if (sp_state != SP_NONE) begin
      emit_mark();
    end
    sp_state = SP_NONE;
    emit_byte(b);
  endfunction

  function automatic void collapse_byte(logic [7:0] b, logic last);
    logic [7:0] want;
    if (hold_n != 2'd0) begin
      want = (hold_n == 2'd1) ? MARK1 : MARK2;
      if (b == want) begin
        if (hold_n >= 2'd2) begin
          // The text opened with the marker itself, so no prefix goes in.
          emit_byte(MARK0);
          emit_byte(MARK1);
          emit_byte(MARK2);
          hold_n = 2'd0;
          hold_data = 16'h0000;
          content_seen = 1'b1;
          sp_state = SP_NONE;
        end else begin
          hold_data[15:8] = b;
          hold_n = 2'd2;
          if (last) release_hold();
        end
        return;
      end
      release_hold();
      collapse_content(b);
      return;
    end
    if (pos == 2'd0 && b == MARK0) begin
      hold_n = 2'd1;
      hold_data = {8'h00, MARK0};
      if (last) release_hold();
      return;
    end
    collapse_content(b);
  endfunction

  function automatic void literal_byte(logic [7:0] b, logic last);
    if (pos == 2'd0 && prefix_on) emit_mark();
    if (b == SPACE) begin
      if (sp_state == SP_NONE) begin
        sp_state = SP_ONE;
      end else if (sp_state == SP_ONE) begin
        emit_byte(SPACE);
        emit_byte(SPACE);
        sp_state = SP_RUN;
      end else begin
        emit_byte(SPACE);
      end
    end else begin
      if (sp_state == SP_ONE) emit_mark();
      sp_state = SP_NONE;
      emit_byte(b);
    end
    if (last && sp_state == SP_ONE) emit_mark();
  endfunction

  function automatic void clear_text();
    sp_state = SP_NONE;
    content_seen = 1'b0;
    hold_n = 2'd0;
    hold_data = 16'h0000;
    pos = 2'd0;
    emitted = 16'h0000;
    ovf_flag = 1'b0;
  endfunction

  function automatic void normalize_step(logic [7:0] b, logic last);
    int        n;
    int        k;
    logic      bare;
    norm_res_t r;
    step_n = 0;
    if (mode_collapse || hold_n != 2'd0) collapse_byte(b, last);
    else literal_byte(b, last);
    if (pos < 2'd3) pos = pos + 2'd1;
    n = step_n;
    bare = 1'b0;
    if (last && n == 0) begin
      bare = 1'b1;
      n = 1;
    end
    for (k = 0; k < n; k++) begin
      r.value = bare ? 8'h00 : step_bytes[k];
      r.valid = !bare;
      r.run_end = (k == n - 1);
      r.txt_end = last && (k == n - 1);
      r.ovf = ovf_flag;
      norm_out_q.push_back(r);
    end
    if (last) clear_text();
  endfunction

  function automatic void check_field(string what, int want, int got);
    if (want != got) begin
      fails++;
      $display("%0t: %s expected %0h, actual %0h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    norm_res_t e;
    if (rst) begin
      mode_collapse = 1'b1;
      prefix_on = 1'b1;
      limit = 16'd8191;
      clear_text();
      norm_out_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_COLLAPSE: mode_collapse = cfg_data[0];
          REG_PREFIX:   prefix_on = cfg_data[0];
          REG_LIMIT:    limit = cfg_data;
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (norm_out_q.size() == 0) begin
          fails++;
          $display("%0t: result expected none, actual byte %02h valid %0b last %0b end %0b",
                   $time, out_byte, byte_valid, run_last, text_end);
        end else begin
          e = norm_out_q.pop_front();
          check_field("out_byte", e.value, out_byte);
          check_field("byte_valid", e.valid, byte_valid);
          check_field("run_last", e.run_end, run_last);
          check_field("text_end", e.txt_end, text_end);
          check_field("overflow", e.ovf, overflow);
        end
      end
      if (push && !full) normalize_step(in_byte, last_in);
    end
    backlog = norm_out_q.size();
  end

endmodule

@@ tb/sv/tb_token_whitespace_normalizer.sv @@
module tb_token_whitespace_normalizer;
  timeunit 1ns;
  timeprecision 1ps;
  import twn_pkg::*;

  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 30;
  localparam int SETTLE       = 8;
  localparam int DRAIN_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 120;
  localparam int HOLD_PHASE   = 6;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = REG_COLLAPSE;
  logic [15:0] cfg_data = 16'h0000;
  logic        push = 1'b0;
  logic [7:0]  in_byte = 8'h00;
  logic        last_in = 1'b0;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        run_last;
  logic        text_end;
  logic        overflow;

  int          check_fails;
  int          backlog;
  bit          calm = 1'b0;
  bit          hold_out = 1'b0;
  bit          drain_failed = 1'b0;
  logic [7:0]  text_buf[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  token_whitespace_normalizer u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .in_byte    (in_byte),
    .last_in    (last_in),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .run_last   (run_last),
    .text_end   (text_end),
    .overflow   (overflow)
  );

  twn_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .in_byte    (in_byte),
    .last_in    (last_in),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .run_last   (run_last),
    .text_end   (text_end),
    .overflow   (overflow),
    .fails      (check_fails),
    .backlog    (backlog)
  );

  function automatic int draw_gap();
    if (calm) return 0;
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
  endfunction

  // Every task below starts and ends right at a rising edge.
  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_byte <= b;
    last_in <= last;
    do @(posedge clk); while (full);
  endtask

  // A cut text leaves its last byte without the end flag, so the text
  // carries on into the next phase under new register settings.
  task automatic send_buf(bit cut);
    int i;
    for (i = 0; i < text_buf.size(); i++)
      send_byte(text_buf[i], (i == text_buf.size() - 1) && !cut);
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    push <= 1'b0;
    do begin
      @(negedge clk);
      waited++;
    end while (backlog != 0 && waited < DRAIN_LIMIT);
    if (backlog != 0) begin
      drain_failed = 1'b1;
      $display("%0t: %0d expected results never arrived", $time, backlog);
    end
    @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(logic collapse, logic prefix, logic [15:0] lim);
    cfg_write <= 1'b1;
    cfg_index <= REG_COLLAPSE;
    cfg_data <= {15'h0000, collapse};
    @(posedge clk);
    cfg_index <= REG_PREFIX;
    cfg_data <= {15'h0000, prefix};
    @(posedge clk);
    cfg_index <= REG_LIMIT;
    cfg_data <= lim;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [7:0] word_byte();
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  // Mostly words split by space runs, some texts opening with all or part
  // of the marker, and some pure noise or pure spaces.
  task automatic build_text();
    int kind;
    int nwords;
    int k;
    text_buf.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 8)) text_buf.push_back(8'($urandom_range(0, 255)));
    end else if (kind == 1) begin
      repeat ($urandom_range(1, 5)) text_buf.push_back(SPACE);
    end else begin
      if (kind == 2) begin
        text_buf.push_back(MARK0);
        if ($urandom_range(0, 3) != 0)
          text_buf.push_back($urandom_range(0, 1) ? MARK1 : word_byte());
        if (text_buf.size() == 2 && text_buf[1] == MARK1 && $urandom_range(0, 3) != 0)
          text_buf.push_back($urandom_range(0, 1) ? MARK2 : word_byte());
      end else if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) text_buf.push_back(SPACE);
      end
      nwords = $urandom_range(1, 3);
      for (k = 0; k < nwords; k++) begin
        if (k > 0) repeat ($urandom_range(1, 3)) text_buf.push_back(SPACE);
        if ($urandom_range(0, 5) == 0) begin
          text_buf.push_back(MARK0);
          text_buf.push_back(MARK1);
          text_buf.push_back(MARK2);
        end else begin
          repeat ($urandom_range(1, 4)) text_buf.push_back(word_byte());
        end
      end
      repeat ($urandom_range(0, 2)) text_buf.push_back(SPACE);
    end
  endtask

  function automatic logic [15:0] pick_limit(int ph);
    case (ph)
      0, 6, 10: return 16'hFFFF;
      1, 2:     return 16'h0000;
      3:        return 16'd8191;
      4:        return 16'($urandom_range(0, 65535));
      5:        return 16'($urandom_range(2, 6));
      7:        return 16'd1;
      8:        return 16'($urandom_range(3, 20));
      9:        return 16'd3;
      default:  return 16'($urandom_range(4, 10));
    endcase
  endfunction

  initial begin : receiver
    int gap;
    repeat (2) @(posedge clk);
    forever begin
      if (hold_out) begin
        // Long hold-off so the block fills up and stalls its input.
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end
      gap = draw_gap();
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  initial begin : watchdog
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int  ph;
    int  n;
    bit  cut;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Registers at their reset values: collapse mode with prefix.
    text_buf = '{SPACE, 8'h61, SPACE, SPACE, 8'h62, SPACE};
    send_buf(1'b0);
    text_buf = '{MARK0, MARK1, MARK2, 8'h78};
    send_buf(1'b0);
    text_buf = '{MARK0};
    send_buf(1'b0);
    text_buf = '{MARK0, MARK1};
    send_buf(1'b0);
    text_buf = '{MARK0, 8'h71};
    send_buf(1'b0);
    text_buf = '{SPACE};
    send_buf(1'b0);
    text_buf = '{8'h00, 8'hFF};
    send_buf(1'b0);
    settle();

    write_regs(1'b0, 1'b1, 16'd8191);
    text_buf = '{SPACE, 8'h61, SPACE, SPACE, 8'h62, SPACE};
    send_buf(1'b0);
    text_buf = '{8'h7A, SPACE};
    send_buf(1'b0);
    settle();

    for (ph = 0; ph < PHASES; ph++) begin
      calm = (ph % 4 == 2);
      write_regs(1'(ph % 2), 1'((ph / 2) % 2), pick_limit(ph));
      if (ph == HOLD_PHASE) hold_out = 1'b1;
      n = 0;
      while (n < PHASE_ITEMS) begin
        build_text();
        cut = (n + text_buf.size() >= PHASE_ITEMS) && (ph < PHASES - 1)
              && ($urandom_range(0, 1) == 1);
        send_buf(cut);
        n += text_buf.size();
      end
      settle();
    end

    if (check_fails == 0 && !drain_failed) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/twn_pkg.sv
rtl/core/twn_front.sv
rtl/core/twn_queue.sv
rtl/core/twn_back.sv
rtl/core/token_whitespace_normalizer.sv
tb/sv/twn_checker.sv
tb/sv/tb_token_whitespace_normalizer.sv
